@@ rtl/utcdst_pkg.sv @@
// ----------------------------------------------------------------------------
// utcdst_pkg
// Shared constants, types and helpers for the UTC / local time converter.
// ----------------------------------------------------------------------------
package utcdst_pkg;

   localparam int unsigned SECS_W   = 32;
   localparam int unsigned RESULT_W = 34;
   localparam int unsigned DAYS_W   = 16;
   localparam int unsigned SOD_W    = 17;
   localparam int unsigned DOE_W    = 18;
   localparam int unsigned YOE_W    = 9;
   localparam int unsigned DOY_W    = 9;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned MDAY_W   = 5;
   localparam int unsigned WDAY_W   = 3;

   // seconds / 86400 = (seconds >> 7) / 675, reciprocal with shift 35
   localparam logic [25:0] RECIP_675   = 26'd50903317;
   localparam int unsigned SHIFT_675   = 35;
   localparam logic [31:0] SECS_PER_DAY = 32'd86400;
   localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;

   // (days + 4) / 7, reciprocal with shift 19
   localparam logic [16:0] RECIP_7     = 17'd74899;
   localparam int unsigned SHIFT_7     = 19;
   localparam logic [DAYS_W-1:0] EPOCH_WDAY = 16'd4;

   // days since 0000-03-01 and the start days of the fourth and fifth 400-year eras
   localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
   localparam logic [19:0] ERA4_START  = 20'd584388;
   localparam logic [19:0] ERA5_START  = 20'd730485;

   localparam logic [18:0] RECIP_1460  = 19'd367720;
   localparam int unsigned SHIFT_1460  = 29;
   localparam logic [18:0] RECIP_365   = 19'd367720;
   localparam int unsigned SHIFT_365   = 27;
   localparam logic [DOE_W-1:0] DAYS_CENTURY = 18'd36524;
   localparam logic [DOE_W-1:0] DAYS_ERA_M1  = 18'd146096;

   localparam int unsigned MONTHS = 12;
   localparam logic [MONTH_W-1:0] MONTH_MARCH   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_OCTOBER = 4'd9;
   localparam logic [5:0] DAYS_MAR_OCT = 6'd31;

   localparam logic [RESULT_W-1:0] OFFSET_SUMMER = 34'd7200;
   localparam logic [RESULT_W-1:0] OFFSET_WINTER = 34'd3600;

   localparam logic OP_UTC_TO_LOCAL = 1'b0;
   localparam logic OP_LOCAL_TO_UTC = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                operation;
      logic [SECS_W-1:0]   secs;
      logic                past_one;
      logic [WDAY_W-1:0]   wday;
      logic [DOE_W-1:0]    doe;
   } day_info_type;

   typedef struct packed {
      logic                valid;
      logic                operation;
      logic [SECS_W-1:0]   secs;
      logic                past_one;
      logic [WDAY_W-1:0]   wday;
      logic [MONTH_W-1:0]  month0;
      logic [MDAY_W-1:0]   mday;
   } date_info_type;

   // first day of year (March based) for each month index
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
      logic [DOY_W-1:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

@@ rtl/utcdst_day_split.sv @@
// ----------------------------------------------------------------------------
// utcdst_day_split
// Three stages: seconds into day count, hour check, weekday and day of era.
// ----------------------------------------------------------------------------
module utcdst_day_split
   import utcdst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [SECS_W-1:0]   in_secs,
   input  logic                in_operation,
   output day_info_type        out_info
);

   // stage 1
   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic [SECS_W-1:0] s1_secs_ff;
   logic [50:0]       s1_prod_ff, s1_prod_in;

   // stage 2
   logic              s2_valid_ff;
   logic              s2_op_ff;
   logic [SECS_W-1:0] s2_secs_ff;
   logic [DAYS_W-1:0] s2_days_ff, s2_days_in;
   logic [31:0]       s2_dsec_ff, s2_dsec_in;
   logic [32:0]       s2_wprod_ff, s2_wprod_in;

   // stage 3
   day_info_type      s3_ff, s3_in;

   logic [DAYS_W-1:0] days_p4;
   logic [31:0]       sod_full;
   logic [13:0]       week_q;
   logic [DAYS_W-1:0] wday_full;
   logic [19:0]       z_days;
   logic [19:0]       doe_full;

   assign s1_prod_in = 51'(in_secs[SECS_W-1:7]) * 51'(RECIP_675);

   assign s2_days_in  = s1_prod_ff[SHIFT_675 +: DAYS_W];
   assign days_p4     = s2_days_in + EPOCH_WDAY;
   assign s2_dsec_in  = 32'(s2_days_in) * SECS_PER_DAY;
   assign s2_wprod_in = 33'(days_p4) * 33'(RECIP_7);

   always_comb begin
      sod_full  = s2_secs_ff - s2_dsec_ff;
      week_q    = s2_wprod_ff[SHIFT_7 +: 14];
      wday_full = (s2_days_ff + EPOCH_WDAY) - DAYS_W'({week_q, 3'b000} - 17'(week_q));
      z_days    = 20'(s2_days_ff) + EPOCH_SHIFT;
      if (z_days >= ERA5_START) begin
         doe_full = z_days - ERA5_START;
      end else begin
         doe_full = z_days - ERA4_START;
      end
      s3_in.valid     = s2_valid_ff;
      s3_in.operation = s2_op_ff;
      s3_in.secs      = s2_secs_ff;
      s3_in.past_one  = sod_full[SOD_W-1:0] >= SECS_PER_HOUR;
      s3_in.wday      = wday_full[WDAY_W-1:0];
      s3_in.doe       = doe_full[DOE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_ff.valid    <= 1'b0;
      end else if (advance) begin
         s1_valid_ff    <= in_valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_ff.valid    <= s3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff        <= in_operation;
         s1_secs_ff      <= in_secs;
         s1_prod_ff      <= s1_prod_in;
         s2_op_ff        <= s1_op_ff;
         s2_secs_ff      <= s1_secs_ff;
         s2_days_ff      <= s2_days_in;
         s2_dsec_ff      <= s2_dsec_in;
         s2_wprod_ff     <= s2_wprod_in;
         s3_ff.operation <= s3_in.operation;
         s3_ff.secs      <= s3_in.secs;
         s3_ff.past_one  <= s3_in.past_one;
         s3_ff.wday      <= s3_in.wday;
         s3_ff.doe       <= s3_in.doe;
      end
   end

   assign out_info = s3_ff;

endmodule

@@ rtl/utcdst_date.sv @@
// ----------------------------------------------------------------------------
// utcdst_date
// Four stages: day of era into year of era, day of year, month and day.
// ----------------------------------------------------------------------------
module utcdst_date
   import utcdst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  day_info_type  in_info,
   output date_info_type out_info
);

   // stage 4
   day_info_type     s4_ff;
   logic [36:0]      s4_p1460_ff, s4_p1460_in;
   logic [2:0]       s4_cent_ff, s4_cent_in;
   logic             s4_last_ff, s4_last_in;

   // stage 5
   day_info_type     s5_ff;
   logic [36:0]      s5_p365_ff, s5_p365_in;

   // stage 6
   day_info_type     s6_ff;
   logic [DOY_W-1:0] s6_doy_ff, s6_doy_in;

   // stage 7
   date_info_type    s7_ff, s7_in;

   logic [6:0]       q1460;
   logic [DOE_W-1:0] t_val;
   logic [YOE_W-1:0] yoe;
   logic [1:0]       yoe_cent;
   logic [DOE_W-1:0] yoe_days;
   logic [DOE_W-1:0] doy_full;
   logic [MONTH_W-1:0] mp;
   logic [DOY_W-1:0] mday_full;

   always_comb begin
      s4_p1460_in = 37'(in_info.doe) * 37'(RECIP_1460);
      s4_cent_in  = 3'(in_info.doe >= DAYS_CENTURY)
                  + 3'(in_info.doe >= DOE_W'(2 * 36524))
                  + 3'(in_info.doe >= DOE_W'(3 * 36524))
                  + 3'(in_info.doe >= DOE_W'(4 * 36524));
      s4_last_in  = in_info.doe == DAYS_ERA_M1;
   end

   always_comb begin
      q1460      = s4_p1460_ff[SHIFT_1460 +: 7];
      t_val      = s4_ff.doe - DOE_W'(q1460) + DOE_W'(s4_cent_ff) - DOE_W'(s4_last_ff);
      s5_p365_in = 37'(t_val) * 37'(RECIP_365);
   end

   always_comb begin
      yoe       = s5_p365_ff[SHIFT_365 +: YOE_W];
      yoe_cent  = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
      yoe_days  = DOE_W'(yoe) * DOE_W'(365) + DOE_W'(yoe[YOE_W-1:2]) - DOE_W'(yoe_cent);
      doy_full  = s5_ff.doe - yoe_days;
      s6_doy_in = doy_full[DOY_W-1:0];
   end

   always_comb begin
      mp = '0;
      for (int i = 1; i < MONTHS; i++) begin
         if (s6_doy_ff >= month_start(MONTH_W'(i))) begin
            mp = MONTH_W'(i);
         end
      end
      mday_full        = s6_doy_ff - month_start(mp) + 9'd1;
      s7_in.valid      = s6_ff.valid;
      s7_in.operation  = s6_ff.operation;
      s7_in.secs       = s6_ff.secs;
      s7_in.past_one   = s6_ff.past_one;
      s7_in.wday       = s6_ff.wday;
      s7_in.month0     = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
      s7_in.mday       = mday_full[MDAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else if (advance) begin
         s4_ff.valid <= in_info.valid;
         s5_ff.valid <= s4_ff.valid;
         s6_ff.valid <= s5_ff.valid;
         s7_ff.valid <= s7_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff.operation <= in_info.operation;
         s4_ff.secs      <= in_info.secs;
         s4_ff.past_one  <= in_info.past_one;
         s4_ff.wday      <= in_info.wday;
         s4_ff.doe       <= in_info.doe;
         s4_p1460_ff     <= s4_p1460_in;
         s4_cent_ff      <= s4_cent_in;
         s4_last_ff      <= s4_last_in;
         s5_ff.operation <= s4_ff.operation;
         s5_ff.secs      <= s4_ff.secs;
         s5_ff.past_one  <= s4_ff.past_one;
         s5_ff.wday      <= s4_ff.wday;
         s5_ff.doe       <= s4_ff.doe;
         s5_p365_ff      <= s5_p365_in;
         s6_ff.operation <= s5_ff.operation;
         s6_ff.secs      <= s5_ff.secs;
         s6_ff.past_one  <= s5_ff.past_one;
         s6_ff.wday      <= s5_ff.wday;
         s6_ff.doe       <= s5_ff.doe;
         s6_doy_ff       <= s6_doy_in;
         s7_ff.operation <= s7_in.operation;
         s7_ff.secs      <= s7_in.secs;
         s7_ff.past_one  <= s7_in.past_one;
         s7_ff.wday      <= s7_in.wday;
         s7_ff.month0    <= s7_in.month0;
         s7_ff.mday      <= s7_in.mday;
      end
   end

   assign out_info = s7_ff;

endmodule

@@ rtl/utcdst_rule.sv @@
// ----------------------------------------------------------------------------
// utcdst_rule
// Summer-time rule, zone offset and the result register.
// ----------------------------------------------------------------------------
module utcdst_rule
   import utcdst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  date_info_type              in_info,
   output logic                       out_valid,
   output logic signed [RESULT_W-1:0] out_converted,
   output logic                       out_summer
);

   logic                out_valid_ff;
   logic [RESULT_W-1:0] out_conv_ff, out_conv_in;
   logic                out_summer_ff, out_summer_in;

   logic [5:0]          week_end;
   logic                after_last_sunday;
   logic [RESULT_W-1:0] offset;

   always_comb begin
      week_end          = 6'd7 - 6'(in_info.wday) + 6'(in_info.mday);
      after_last_sunday = (week_end > DAYS_MAR_OCT)
                        && ((in_info.wday != 3'd0) || in_info.past_one);
      if ((in_info.month0 < MONTH_MARCH) || (in_info.month0 > MONTH_OCTOBER)) begin
         out_summer_in = 1'b0;
      end else if ((in_info.month0 > MONTH_MARCH) && (in_info.month0 < MONTH_OCTOBER)) begin
         out_summer_in = 1'b1;
      end else if (in_info.month0 == MONTH_MARCH) begin
         out_summer_in = after_last_sunday;
      end else begin
         out_summer_in = !after_last_sunday;
      end
      offset = out_summer_in ? OFFSET_SUMMER : OFFSET_WINTER;
      if (in_info.operation == OP_LOCAL_TO_UTC) begin
         out_conv_in = RESULT_W'(in_info.secs) - offset;
      end else begin
         out_conv_in = RESULT_W'(in_info.secs) + offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_info.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_conv_ff   <= out_conv_in;
         out_summer_ff <= out_summer_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_converted = signed'(out_conv_ff);
   assign out_summer    = out_summer_ff;

endmodule

@@ rtl/utc_local_time_dst_convert.sv @@
// ----------------------------------------------------------------------------
// utc_local_time_dst_convert
// Converts epoch seconds between UTC and central European local time.
// ----------------------------------------------------------------------------
// Each transaction carries a 32-bit epoch second count and a direction
// (0: UTC to local, 1: local to UTC). The count is broken into a calendar
// date, and the EU summer-time rule (switch at 01:00 on the last Sunday of
// March and October) picks an offset of 7200 or 3600 seconds, which is added
// or subtracted. For local to UTC the rule is tested on the local value. The
// block is an eight-stage pipeline: it takes one transaction every cycle while
// the output is not stalled. A stalled output holds the whole pipeline, so the
// input is stalled only while a result waits.
// ----------------------------------------------------------------------------
module utc_local_time_dst_convert
   import utcdst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SECS_W-1:0]          req_epoch_seconds,
   input  logic                       req_operation,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_converted_seconds,
   output logic                       rsp_summer_time
);

   logic          advance;
   day_info_type  day_info;
   date_info_type date_info;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   utcdst_day_split u_day_split (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_secs      (req_epoch_seconds),
      .in_operation (req_operation),
      .out_info     (day_info)
   );

   utcdst_date u_date (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_info  (day_info),
      .out_info (date_info)
   );

   utcdst_rule u_rule (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_info       (date_info),
      .out_valid     (rsp_valid),
      .out_converted (rsp_converted_seconds),
      .out_summer    (rsp_summer_time)
   );

endmodule
